/* rtl/rvx_pkg.sv */
// shared types and constants for the rv32i integer execute block
package rvx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_IDX_W = 5;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // alu function codes (fn3)
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLL  = 3'd1;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SRL  = 3'd5;
  localparam logic [2:0] ALU_OR   = 3'd6;
  localparam logic [2:0] ALU_AND  = 3'd7;

  // branch condition codes (fn3)
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  // fn7 values
  localparam logic [6:0] FN7_BASE = 7'h00;
  localparam logic [6:0] FN7_ALT  = 7'h20;

  // status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_UNSUP = 1'b1;

  typedef struct packed {
    logic [XLEN-1:0] instr_word;
  } instr_t;

  typedef struct packed {
    logic [XLEN-1:0] reset_vector;
  } cfg_t;

  typedef struct packed {
    logic [XLEN-1:0]      next_pc;
    logic                 reg_write;
    logic [REG_IDX_W-1:0] dest_index;
    logic [XLEN-1:0]      dest_value;
    logic                 exec_status;
  } result_t;

  // register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

endpackage

/* rtl/rvx_stream_if.sv */
// valid/ready channel interface with a typed payload
interface rvx_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rvx_regfile.sv */
// register file memory with reset valid bits and write forwarding
module rvx_regfile #(
  parameter int unsigned REG_COUNT = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [rvx_pkg::REG_IDX_W-1:0] rs1_i,
  input  logic [rvx_pkg::REG_IDX_W-1:0] rs2_i,
  output logic [rvx_pkg::XLEN-1:0]      rdata1_o,
  output logic [rvx_pkg::XLEN-1:0]      rdata2_o,
  input  rvx_pkg::rf_wr_t               wr_i
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [rvx_pkg::XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0]          valid_q;
  logic [rvx_pkg::XLEN-1:0]      rd1_q, rd2_q;
  logic                          hit1_q, hit2_q;
  logic [rvx_pkg::REG_IDX_W-1:0] idx1_q, idx2_q;
  logic                          last_en_q;
  logic [rvx_pkg::REG_IDX_W-1:0] last_idx_q;
  logic [rvx_pkg::XLEN-1:0]      last_data_q;
  logic                          in1, in2;

  assign in1 = (32'(rs1_i) < REG_COUNT);
  assign in2 = (32'(rs2_i) < REG_COUNT);

  // storage array and synchronous read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx[AW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd1_q  <= mem[rs1_i[AW-1:0]];
      rd2_q  <= mem[rs2_i[AW-1:0]];
      idx1_q <= rs1_i;
      idx2_q <= rs2_i;
    end
  end

  // written flags, cleared at reset so untouched entries read zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit1_q  <= 1'b0;
      hit2_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx[AW-1:0]] <= 1'b1;
      end
      if (rd_en_i) begin
        hit1_q <= in1 && valid_q[rs1_i[AW-1:0]];
        hit2_q <= in2 && valid_q[rs2_i[AW-1:0]];
      end
    end
  end

  // most recent write, forwarded over a read taken at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_en_q <= 1'b0;
    end else if (wr_i.en) begin
      last_en_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      last_idx_q  <= wr_i.idx;
      last_data_q <= wr_i.data;
    end
  end

  // read data select
  always_comb begin
    if (last_en_q && (last_idx_q == idx1_q)) begin
      rdata1_o = last_data_q;
    end else begin
      rdata1_o = hit1_q ? rd1_q : '0;
    end
    if (last_en_q && (last_idx_q == idx2_q)) begin
      rdata2_o = last_data_q;
    end else begin
      rdata2_o = hit2_q ? rd2_q : '0;
    end
  end

endmodule

/* rtl/rvx_exec.sv */
// instruction decode, alu, branch and next pc logic
module rvx_exec #(
  parameter int unsigned REG_COUNT = 32
) (
  input  logic [rvx_pkg::XLEN-1:0] instr_i,
  input  logic [rvx_pkg::XLEN-1:0] pc_i,
  input  logic [rvx_pkg::XLEN-1:0] a_i,
  input  logic [rvx_pkg::XLEN-1:0] b_i,
  output rvx_pkg::result_t         res_o,
  output rvx_pkg::rf_wr_t          wr_o
);

  logic [6:0]                    opc;
  logic [rvx_pkg::REG_IDX_W-1:0] rd;
  logic [2:0]                    fn3;
  logic [6:0]                    fn7;
  logic [31:0]                   imm_i, imm_u, imm_j, imm_b;
  logic [31:0]                   pc4, op_b, alu_res, val, next;
  logic                          alt, wr, bad, take, lt, ltu;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign fn3 = instr_i[14:12];
  assign fn7 = instr_i[31:25];

  // immediates
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_u = {instr_i[31:12], 12'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign pc4   = pc_i + 32'd4;

  // alu operand and alternate select
  always_comb begin
    if (opc == rvx_pkg::OPC_OP) begin
      op_b = b_i;
      alt  = (fn7 == rvx_pkg::FN7_ALT);
    end else begin
      op_b = ((fn3 == rvx_pkg::ALU_SLL) || (fn3 == rvx_pkg::ALU_SRL))
             ? {27'b0, instr_i[24:20]} : imm_i;
      alt  = (fn3 == rvx_pkg::ALU_SRL) && (fn7 == rvx_pkg::FN7_ALT);
    end
  end

  // alu
  always_comb begin
    case (fn3)
      rvx_pkg::ALU_ADD:  alu_res = alt ? (a_i - op_b) : (a_i + op_b);
      rvx_pkg::ALU_SLL:  alu_res = a_i << op_b[4:0];
      rvx_pkg::ALU_SLT:  alu_res = {31'b0, $signed(a_i) < $signed(op_b)};
      rvx_pkg::ALU_SLTU: alu_res = {31'b0, a_i < op_b};
      rvx_pkg::ALU_XOR:  alu_res = a_i ^ op_b;
      rvx_pkg::ALU_SRL:  alu_res = alt ? 32'($signed(a_i) >>> op_b[4:0])
                                       : (a_i >> op_b[4:0]);
      rvx_pkg::ALU_OR:   alu_res = a_i | op_b;
      default:           alu_res = a_i & op_b;
    endcase
  end

  // branch compare
  assign lt  = $signed(a_i) < $signed(b_i);
  assign ltu = a_i < b_i;

  always_comb begin
    take = 1'b0;
    unique case (fn3)
      rvx_pkg::BR_EQ:  take = (a_i == b_i);
      rvx_pkg::BR_NE:  take = (a_i != b_i);
      rvx_pkg::BR_LT:  take = lt;
      rvx_pkg::BR_GE:  take = !lt;
      rvx_pkg::BR_LTU: take = ltu;
      rvx_pkg::BR_GEU: take = !ltu;
      default:         take = 1'b0;
    endcase
  end

  // opcode decode
  always_comb begin
    val  = '0;
    wr   = 1'b0;
    bad  = 1'b0;
    next = pc4;
    unique case (opc)
      rvx_pkg::OPC_LUI: begin
        val = imm_u;
        wr  = 1'b1;
      end
      rvx_pkg::OPC_AUIPC: begin
        val = pc_i + imm_u;
        wr  = 1'b1;
      end
      rvx_pkg::OPC_JAL: begin
        val  = pc4;
        wr   = 1'b1;
        next = pc_i + imm_j;
      end
      rvx_pkg::OPC_JALR: begin
        if (fn3 != 3'd0) begin
          bad = 1'b1;
        end else begin
          val  = pc4;
          wr   = 1'b1;
          next = (a_i + imm_i) & 32'hFFFF_FFFE;
        end
      end
      rvx_pkg::OPC_BRANCH: begin
        if ((fn3 == 3'd2) || (fn3 == 3'd3)) begin
          bad = 1'b1;
        end else if (take) begin
          next = pc_i + imm_b;
        end
      end
      rvx_pkg::OPC_OPIMM: begin
        if ((fn3 == rvx_pkg::ALU_SLL) && (fn7 != rvx_pkg::FN7_BASE)) begin
          bad = 1'b1;
        end else if ((fn3 == rvx_pkg::ALU_SRL) && (fn7 != rvx_pkg::FN7_BASE)
                     && (fn7 != rvx_pkg::FN7_ALT)) begin
          bad = 1'b1;
        end else begin
          val = alu_res;
          wr  = 1'b1;
        end
      end
      rvx_pkg::OPC_OP: begin
        if ((fn7 == rvx_pkg::FN7_ALT) && (fn3 != rvx_pkg::ALU_ADD)
            && (fn3 != rvx_pkg::ALU_SRL)) begin
          bad = 1'b1;
        end else if ((fn7 != rvx_pkg::FN7_BASE) && (fn7 != rvx_pkg::FN7_ALT)) begin
          bad = 1'b1;
        end else begin
          val = alu_res;
          wr  = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    // unsupported ones fall back to pc + 4
    if (bad) begin
      next = pc4;
    end
  end

  // destination x0 or beyond the file discards the write
  always_comb begin
    wr_o.en   = wr && !bad && (rd != '0) && (32'(rd) < REG_COUNT);
    wr_o.idx  = rd;
    wr_o.data = val;
  end

  assign res_o.next_pc     = next;
  assign res_o.reg_write   = wr_o.en;
  assign res_o.dest_index  = wr_o.en ? rd : '0;
  assign res_o.dest_value  = wr_o.en ? val : '0;
  assign res_o.exec_status = bad ? rvx_pkg::STAT_UNSUP : rvx_pkg::STAT_OK;

endmodule

/* rtl/rv32i_integer_execute.sv */
// top level of the rv32i integer execute block
//
// instr_i carries one 32-bit instruction per transfer; it runs at the current
// program counter. result_o returns one item per instruction: next pc, the
// register write (flag, index, value) and the status (unsupported opcodes are
// no-ops that step pc by 4). cfg_i writes reset_vector, which loads the pc at
// once; write it only while the block is idle.
// pipeline: the register file read port and the instruction are registered at the
// transfer edge; execute and write-back then run from the execute slot, whose
// retirement loads the result register.
// throughput: one instruction per cycle while the result is not held; the synchronous
// register file read overlaps the previous instruction's write-back, which is forwarded.
// reset: pc goes to zero, the register file reads as all zero (per-entry
// valid flags cleared), both pipeline slots empty. no clearing pass.
// stall: a held result blocks execute; one instruction may still be taken
// into the read slot, after which instr_i.ready drops until the output moves.
module rv32i_integer_execute #(
  parameter int unsigned REG_COUNT = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  rvx_stream_if.sink   instr_i,
  rvx_stream_if.sink   cfg_i,
  rvx_stream_if.source result_o
);

  logic                     accept, fire, cfg_fire;
  logic                     s1_valid_q, out_valid_q;
  logic [rvx_pkg::XLEN-1:0] instr_q, pc_q, rs1_val, rs2_val;
  rvx_pkg::instr_t          in_data;
  rvx_pkg::cfg_t            cfg_data;
  rvx_pkg::result_t         ex_res, out_data_q;
  rvx_pkg::rf_wr_t          ex_wr, rf_wr;

  assign in_data  = instr_i.data;
  assign cfg_data = cfg_i.data;

  // handshakes
  assign cfg_i.ready   = 1'b1;
  assign cfg_fire      = cfg_i.valid;
  assign fire          = s1_valid_q && (!out_valid_q || result_o.ready);
  assign instr_i.ready = !s1_valid_q || fire;
  assign accept        = instr_i.valid && instr_i.ready;

  // register file, read at transfer, written when the instruction retires
  rvx_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rs1_i    (in_data.instr_word[19:15]),
    .rs2_i    (in_data.instr_word[24:20]),
    .rdata1_o (rs1_val),
    .rdata2_o (rs2_val),
    .wr_i     (rf_wr)
  );

  rvx_exec #(
    .REG_COUNT(REG_COUNT)
  ) u_exec (
    .instr_i (instr_q),
    .pc_i    (pc_q),
    .a_i     (rs1_val),
    .b_i     (rs2_val),
    .res_o   (ex_res),
    .wr_o    (ex_wr)
  );

  always_comb begin
    rf_wr    = ex_wr;
    rf_wr.en = ex_wr.en && fire;
  end

  // execute slot and program counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pc_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        pc_q <= cfg_data.reset_vector;
      end else if (fire) begin
        pc_q <= ex_res.next_pc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= in_data.instr_word;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= ex_res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  // checks
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> (rf_wr.idx != '0))
    else $error("write to x0 issued");

  a_unsup_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (ex_res.exec_status == rvx_pkg::STAT_UNSUP)) |-> !rf_wr.en)
    else $error("unsupported instruction wrote the register file");

  a_pc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !cfg_fire) |=> (pc_q == out_data_q.next_pc))
    else $error("pc differs from reported next pc");

  a_slot_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !fire) |=> (s1_valid_q && $stable(instr_q)))
    else $error("stalled instruction lost");

endmodule

/* tb/sv/tb_rv32i_integer_execute.sv */
// testbench for the rv32i integer execute block with a self-checking predictor
`timescale 1ns / 100ps

module tb_rv32i_integer_execute;

  localparam int unsigned REG_COUNT      = 32;
  localparam int unsigned EXEC_LATENCY   = 2;
  localparam int unsigned IDLE_PCT       = 14;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // encodings the block does not execute, and field values used by the tests
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] FN7_BAD    = 7'h01;
  localparam logic [2:0] FN3_ZERO   = 3'd0;
  localparam logic [2:0] FN3_ONE    = 3'd1;
  localparam logic [2:0] FN3_WORD   = 3'd2;
  localparam logic [2:0] BR_RSVD    = 3'd2;
  localparam logic [4:0] REG_ZERO   = 5'd0;

  logic clk = 1'b0;
  logic rst_n;

  rvx_stream_if #(.T(rvx_pkg::instr_t))  instr_if ();
  rvx_stream_if #(.T(rvx_pkg::cfg_t))    cfg_if ();
  rvx_stream_if #(.T(rvx_pkg::result_t)) result_if ();

  rv32i_integer_execute #(.REG_COUNT(REG_COUNT)) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .instr_i  (instr_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // architectural state tracked alongside the block
  logic [31:0]      arch_regs [REG_COUNT];
  logic [31:0]      arch_pc;
  logic [31:0]      arch_reset_vector;
  rvx_pkg::result_t pending_results [$];

  int unsigned gap_pct = IDLE_PCT;
  int unsigned result_hold = 0;
  logic        instr_offered = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned instr_count = 0;
  int unsigned result_count = 0;
  int unsigned unsup_count = 0;
  int unsigned taken_count = 0;
  int unsigned cfg_count = 0;
  int unsigned stall_cycles = 0;

  // instruction encoders
  function automatic logic [31:0] enc_r(input logic [6:0] fn7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] fn3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {fn7, rs2, rs1, fn3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] fn3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, fn3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvx_pkg::OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] fn3);
    return {imm[12], imm[10:5], rs2, rs1, fn3, imm[4:1], imm[11], rvx_pkg::OPC_BRANCH};
  endfunction

  // register read, x0 and out-of-range indexes give zero
  function automatic logic [31:0] read_reg(input logic [4:0] idx);
    if (idx == REG_ZERO || int'(idx) >= REG_COUNT) return 32'd0;
    return arch_regs[idx];
  endfunction

  function automatic logic [31:0] alu_result(input logic [2:0] fn3, input logic alt,
                                             input logic [31:0] a, input logic [31:0] b);
    logic [31:0] sra;
    sra = $signed(a) >>> b[4:0];
    case (fn3)
      rvx_pkg::ALU_ADD:  return alt ? a - b : a + b;
      rvx_pkg::ALU_SLL:  return a << b[4:0];
      rvx_pkg::ALU_SLT:  return {31'd0, $signed(a) < $signed(b)};
      rvx_pkg::ALU_SLTU: return {31'd0, a < b};
      rvx_pkg::ALU_XOR:  return a ^ b;
      rvx_pkg::ALU_SRL: begin
        if (alt) return sra;
        return a >> b[4:0];
      end
      rvx_pkg::ALU_OR:   return a | b;
      default:           return a & b;
    endcase
  endfunction

  // execute one instruction on the tracked state, return the expected result
  function automatic rvx_pkg::result_t execute_instr(input logic [31:0] w);
    logic [6:0]       opc, fn7;
    logic [4:0]       rd;
    logic [2:0]       fn3;
    logic [31:0]      a, b, pc, nxt, val, imm_i, imm_b;
    logic             wr, bad, take;
    rvx_pkg::result_t res;
    opc   = w[6:0];
    rd    = w[11:7];
    fn3   = w[14:12];
    fn7   = w[31:25];
    a     = read_reg(w[19:15]);
    b     = read_reg(w[24:20]);
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    pc    = arch_pc;
    nxt   = pc + 32'd4;
    val   = 32'd0;
    wr    = 1'b0;
    bad   = 1'b0;
    take  = 1'b0;
    case (opc)
      rvx_pkg::OPC_LUI: begin
        val = {w[31:12], 12'd0};
        wr  = 1'b1;
      end
      rvx_pkg::OPC_AUIPC: begin
        val = pc + {w[31:12], 12'd0};
        wr  = 1'b1;
      end
      rvx_pkg::OPC_JAL: begin
        val = pc + 32'd4;
        wr  = 1'b1;
        nxt = pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      rvx_pkg::OPC_JALR: begin
        if (fn3 != FN3_ZERO) begin
          bad = 1'b1;
        end else begin
          val = pc + 32'd4;
          wr  = 1'b1;
          nxt = (a + imm_i) & 32'hFFFF_FFFE;
        end
      end
      rvx_pkg::OPC_BRANCH: begin
        case (fn3)
          rvx_pkg::BR_EQ:  take = (a == b);
          rvx_pkg::BR_NE:  take = (a != b);
          rvx_pkg::BR_LT:  take = ($signed(a) < $signed(b));
          rvx_pkg::BR_GE:  take = !($signed(a) < $signed(b));
          rvx_pkg::BR_LTU: take = (a < b);
          rvx_pkg::BR_GEU: take = (a >= b);
          default:         bad = 1'b1;
        endcase
        if (take) begin
          nxt = pc + imm_b;
          taken_count++;
        end
      end
      rvx_pkg::OPC_OPIMM: begin
        if (fn3 == rvx_pkg::ALU_SLL && fn7 != rvx_pkg::FN7_BASE) begin
          bad = 1'b1;
        end else if (fn3 == rvx_pkg::ALU_SRL && fn7 != rvx_pkg::FN7_BASE &&
                     fn7 != rvx_pkg::FN7_ALT) begin
          bad = 1'b1;
        end else begin
          val = alu_result(fn3, fn3 == rvx_pkg::ALU_SRL && fn7 == rvx_pkg::FN7_ALT, a,
                           (fn3 == rvx_pkg::ALU_SLL || fn3 == rvx_pkg::ALU_SRL)
                           ? {27'd0, w[24:20]} : imm_i);
          wr  = 1'b1;
        end
      end
      rvx_pkg::OPC_OP: begin
        if (fn7 == rvx_pkg::FN7_ALT && fn3 != rvx_pkg::ALU_ADD &&
            fn3 != rvx_pkg::ALU_SRL) begin
          bad = 1'b1;
        end else if (fn7 != rvx_pkg::FN7_BASE && fn7 != rvx_pkg::FN7_ALT) begin
          bad = 1'b1;
        end else begin
          val = alu_result(fn3, fn7 == rvx_pkg::FN7_ALT, a, b);
          wr  = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    // unsupported is a no-op that steps pc by 4
    if (bad) begin
      wr  = 1'b0;
      nxt = pc + 32'd4;
      unsup_count++;
    end
    // writes to x0 or beyond the file are dropped
    if (wr && (rd == REG_ZERO || int'(rd) >= REG_COUNT)) wr = 1'b0;
    if (wr) arch_regs[rd] = val;
    arch_pc = nxt;
    res.next_pc     = nxt;
    res.reg_write   = wr;
    res.dest_index  = wr ? rd : REG_ZERO;
    res.dest_value  = wr ? val : 32'd0;
    res.exec_status = bad ? rvx_pkg::STAT_UNSUP : rvx_pkg::STAT_OK;
    return res;
  endfunction

  // mostly well-formed instructions with random operands, some broken ones and noise
  function automatic logic [31:0] random_instr();
    int unsigned pick;
    logic [31:0] r, w;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  fn3;
    logic [6:0]  fn7;
    pick = $urandom_range(99);
    r    = $urandom;
    rd   = 5'($urandom);
    rs1  = 5'($urandom);
    rs2  = 5'($urandom);
    fn3  = 3'($urandom);
    if (pick < 10) begin
      w = enc_u(r[31:12], rd, rvx_pkg::OPC_LUI);
    end else if (pick < 15) begin
      w = enc_u(r[31:12], rd, rvx_pkg::OPC_AUIPC);
    end else if (pick < 45) begin
      case (fn3)
        rvx_pkg::ALU_SLL: fn7 = rvx_pkg::FN7_BASE;
        rvx_pkg::ALU_SRL: fn7 = r[0] ? rvx_pkg::FN7_ALT : rvx_pkg::FN7_BASE;
        default:          fn7 = r[31:25];
      endcase
      w = enc_r(fn7, rs2, rs1, fn3, rd, rvx_pkg::OPC_OPIMM);
    end else if (pick < 70) begin
      fn7 = (r[0] && (fn3 == rvx_pkg::ALU_ADD || fn3 == rvx_pkg::ALU_SRL))
            ? rvx_pkg::FN7_ALT : rvx_pkg::FN7_BASE;
      w = enc_r(fn7, rs2, rs1, fn3, rd, rvx_pkg::OPC_OP);
    end else if (pick < 82) begin
      case ($urandom_range(5))
        0:       fn3 = rvx_pkg::BR_EQ;
        1:       fn3 = rvx_pkg::BR_NE;
        2:       fn3 = rvx_pkg::BR_LT;
        3:       fn3 = rvx_pkg::BR_GE;
        4:       fn3 = rvx_pkg::BR_LTU;
        default: fn3 = rvx_pkg::BR_GEU;
      endcase
      w = enc_b(r[12:0], rs2, rs1, fn3);
    end else if (pick < 87) begin
      w = enc_j(r[20:0], rd);
    end else if (pick < 92) begin
      w = enc_i(r[31:20], rs1, FN3_ZERO, rd, rvx_pkg::OPC_JALR);
    end else if (pick < 96) begin
      // random fields under a real opcode, often malformed
      w = r;
      case ($urandom_range(6))
        0:       w[6:0] = rvx_pkg::OPC_OP;
        1:       w[6:0] = rvx_pkg::OPC_OPIMM;
        2:       w[6:0] = rvx_pkg::OPC_BRANCH;
        3:       w[6:0] = rvx_pkg::OPC_JALR;
        4:       w[6:0] = OPC_LOAD;
        5:       w[6:0] = OPC_STORE;
        default: w[6:0] = OPC_FENCE;
      endcase
    end else begin
      w = r;
    end
    return w;
  endfunction

  // offer one instruction, predict its result once transferred
  task automatic send_instr(input logic [31:0] w);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      if (instr_offered) begin
        instr_if.valid <= 1'b0;
        instr_offered = 1'b0;
      end
      @(posedge clk);
    end
    instr_if.valid <= 1'b1;
    instr_if.data  <= rvx_pkg::instr_t'(w);
    instr_offered = 1'b1;
    do @(posedge clk); while (!instr_if.ready);
    pending_results.push_back(execute_instr(w));
    instr_count++;
  endtask

  // stop offering and wait for every predicted result
  task automatic drain_results();
    if (instr_offered) begin
      instr_if.valid <= 1'b0;
      instr_offered = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // reset_vector write while the pipeline is empty
  task automatic write_reset_vector(input logic [31:0] v);
    drain_results();
    repeat (EXEC_LATENCY + 1) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= rvx_pkg::cfg_t'(v);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    arch_reset_vector = v;
    arch_pc = v;
    cfg_count++;
  endtask

  function automatic void report_mismatch(input string field, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    mismatch_count++;
  endfunction

  // result side: random stalls, long hold-off on request, field checks
  always @(posedge clk) begin : result_check
    rvx_pkg::result_t exp_r;
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result_if.data);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (result_if.data.next_pc !== exp_r.next_pc)
            report_mismatch("next_pc", exp_r.next_pc, result_if.data.next_pc);
          if (result_if.data.reg_write !== exp_r.reg_write)
            report_mismatch("reg_write", 32'(exp_r.reg_write),
                            32'(result_if.data.reg_write));
          if (result_if.data.dest_index !== exp_r.dest_index)
            report_mismatch("dest_index", 32'(exp_r.dest_index),
                            32'(result_if.data.dest_index));
          if (result_if.data.dest_value !== exp_r.dest_value)
            report_mismatch("dest_value", exp_r.dest_value, result_if.data.dest_value);
          if (result_if.data.exec_status !== exp_r.exec_status)
            report_mismatch("exec_status", 32'(exp_r.exec_status),
                            32'(result_if.data.exec_status));
        end
      end
      if (result_hold != 0) begin
        result_if.ready <= 1'b0;
        result_hold--;
      end else begin
        result_if.ready <= (gap_pct == 0) || ($urandom_range(99) >= gap_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((instr_if.valid && instr_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (result_if.valid && result_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("rv32i_integer_execute verification failed");
        $finish;
      end
    end
  end

  // every alu function with extreme operands, x0 destination
  task automatic test_alu_ops();
    send_instr(enc_u(20'h80000, 5'd1, rvx_pkg::OPC_LUI));
    send_instr(enc_i(12'hFFF, REG_ZERO, rvx_pkg::ALU_ADD, 5'd2, rvx_pkg::OPC_OPIMM));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_ADD, 5'd3, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_ALT, 5'd2, 5'd1, rvx_pkg::ALU_ADD, 5'd4, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd2, rvx_pkg::ALU_SLL, 5'd5, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_SLT, 5'd6, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_SLTU, 5'd7,
                     rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_XOR, 5'd8, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_SRL, 5'd9, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_ALT, 5'd2, 5'd1, rvx_pkg::ALU_SRL, 5'd10, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_OR, REG_ZERO,
                     rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd2, 5'd1, rvx_pkg::ALU_AND, 5'd11,
                     rvx_pkg::OPC_OP));
    send_instr(enc_i(12'h7FF, 5'd1, rvx_pkg::ALU_SLT, 5'd12, rvx_pkg::OPC_OPIMM));
    send_instr(enc_i(12'hFFF, 5'd2, rvx_pkg::ALU_SLTU, 5'd13, rvx_pkg::OPC_OPIMM));
    send_instr(enc_i(12'h800, 5'd2, rvx_pkg::ALU_XOR, 5'd14, rvx_pkg::OPC_OPIMM));
    send_instr(enc_i(12'h555, REG_ZERO, rvx_pkg::ALU_OR, 5'd15, rvx_pkg::OPC_OPIMM));
    send_instr(enc_i(12'hFFF, 5'd1, rvx_pkg::ALU_AND, 5'd16, rvx_pkg::OPC_OPIMM));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd31, 5'd2, rvx_pkg::ALU_SLL, 5'd17,
                     rvx_pkg::OPC_OPIMM));
    send_instr(enc_r(rvx_pkg::FN7_BASE, 5'd31, 5'd1, rvx_pkg::ALU_SRL, 5'd18,
                     rvx_pkg::OPC_OPIMM));
    send_instr(enc_r(rvx_pkg::FN7_ALT, 5'd31, 5'd1, rvx_pkg::ALU_SRL, 5'd19,
                     rvx_pkg::OPC_OPIMM));
    drain_results();
  endtask

  // upper immediates, jumps with rd equal to rs1, misaligned targets, all branches
  task automatic test_control_flow();
    send_instr(enc_u(20'hFFFFF, 5'd20, rvx_pkg::OPC_AUIPC));
    send_instr(enc_j(21'h0FFFFE, 5'd21));
    send_instr(enc_j(21'h1FFFFC, 5'd23));
    send_instr(enc_i(12'h001, 5'd3, FN3_ZERO, 5'd3, rvx_pkg::OPC_JALR));
    send_instr(enc_i(12'h7FF, 5'd2, FN3_ZERO, 5'd24, rvx_pkg::OPC_JALR));
    send_instr(enc_b(13'h0FFE, 5'd1, 5'd1, rvx_pkg::BR_EQ));
    send_instr(enc_b(13'h1000, 5'd2, 5'd1, rvx_pkg::BR_NE));
    send_instr(enc_b(13'h0002, 5'd2, 5'd1, rvx_pkg::BR_LT));
    send_instr(enc_b(13'h0010, 5'd2, 5'd1, rvx_pkg::BR_GE));
    send_instr(enc_b(13'h0010, 5'd1, 5'd2, rvx_pkg::BR_LTU));
    send_instr(enc_b(13'h1FFE, 5'd1, 5'd2, rvx_pkg::BR_GEU));
    drain_results();
  endtask

  // encodings outside the supported set behave as pc + 4 no-ops
  task automatic test_unsupported();
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr(enc_i(12'h008, 5'd1, FN3_WORD, 5'd8, OPC_LOAD));
    send_instr(enc_i(12'h000, REG_ZERO, FN3_ZERO, REG_ZERO, OPC_SYSTEM));
    send_instr(enc_i(12'h004, 5'd2, FN3_ONE, 5'd6, rvx_pkg::OPC_JALR));
    send_instr(enc_b(13'h0004, 5'd1, 5'd1, BR_RSVD));
    send_instr(enc_r(rvx_pkg::FN7_ALT, 5'd2, 5'd1, rvx_pkg::ALU_SLL, 5'd7, rvx_pkg::OPC_OP));
    send_instr(enc_r(FN7_BAD, 5'd2, 5'd1, rvx_pkg::ALU_ADD, 5'd7, rvx_pkg::OPC_OP));
    send_instr(enc_r(rvx_pkg::FN7_ALT, 5'd3, 5'd1, rvx_pkg::ALU_SLL, 5'd7,
                     rvx_pkg::OPC_OPIMM));
    drain_results();
  endtask

  // reset_vector at its extremes and in between, a short program after each
  task automatic test_reset_vector();
    logic [31:0] vectors [5];
    vectors[0] = 32'hFFFF_FFFF;
    vectors[1] = 32'h0000_0000;
    vectors[2] = 32'h8000_0000;
    vectors[3] = $urandom;
    vectors[4] = 32'hFFFF_FFFC;
    foreach (vectors[i]) begin
      write_reset_vector(vectors[i]);
      repeat (12) send_instr(random_instr());
    end
    drain_results();
  endtask

  // result side held off long while instructions keep coming
  task automatic test_backpressure();
    @(negedge clk);
    result_hold = HOLD_CYCLES;
    gap_pct = 0;
    @(posedge clk);
    repeat (16) send_instr(random_instr());
    drain_results();
    gap_pct = IDLE_PCT;
  endtask

  // long random stream, one segment without any idle cycles
  task automatic test_random_stream();
    for (int seg = 0; seg < 8; seg++) begin
      gap_pct = (seg == 3) ? 0 : IDLE_PCT;
      repeat (50) send_instr(random_instr());
    end
    drain_results();
    gap_pct = IDLE_PCT;
  endtask

  initial begin
    rst_n = 1'b0;
    instr_if.valid = 1'b0;
    instr_if.data  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    foreach (arch_regs[i]) arch_regs[i] = 32'd0;
    arch_reset_vector = 32'd0;
    arch_pc = arch_reset_vector;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alu_ops();
    test_control_flow();
    test_unsupported();
    test_reset_vector();
    test_backpressure();
    test_random_stream();

    drain_results();
    repeat (EXEC_LATENCY + 4) @(posedge clk);
    $display("%0d instructions executed, %0d unsupported, %0d branches taken, %0d results checked",
             instr_count, unsup_count, taken_count, result_count);
    $display("%0d reset_vector writes, receiver hold-off and gap-free stretches included",
             cfg_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("rv32i_integer_execute verification clean");
    end else begin
      $display("rv32i_integer_execute verification failed");
    end
    $finish;
  end

endmodule
